[sv/tcsm_pkg.sv]
package tcsm_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned WIN_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SEQ_W-1:0] TIME_WAIT_TICKS_RST = 32'd120;
  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 16'd51200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WAIT_TICKS = 1'b0,
    CFG_WINDOW_SIZE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_CONNECT = 3'd0,
    OP_LISTEN  = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_SEGMENT = 3'd3,
    OP_TICK    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_ERROR   = 2'd2,
    ST_PENDING = 2'd3
  } call_status_t;

  typedef enum logic [3:0] {
    CONN_CLOSED      = 4'd0,
    CONN_LISTEN      = 4'd1,
    CONN_SYN_SENT    = 4'd2,
    CONN_SYN_RCVD    = 4'd3,
    CONN_SYN_SIMRCVD = 4'd4,
    CONN_ESTABLISHED = 4'd5,
    CONN_FIN_WAIT_1  = 4'd6,
    CONN_FIN_WAIT_2  = 4'd7,
    CONN_CLOSE_WAIT  = 4'd8,
    CONN_CLOSING     = 4'd9,
    CONN_LAST_ACK    = 4'd10,
    CONN_TIME_WAIT   = 4'd11
  } conn_state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic             seg_syn;
    logic             seg_ack;
    logic             seg_fin;
    logic [SEQ_W-1:0] seg_seq;
    logic [SEQ_W-1:0] seg_ack_num;
    logic [SEQ_W-1:0] initial_seq;
  } in_item_t;

  typedef struct packed {
    logic             send_valid;
    logic             send_syn;
    logic             send_ack;
    logic             send_fin;
    logic [SEQ_W-1:0] send_seq;
    logic [SEQ_W-1:0] send_ack_num;
    logic [WIN_W-1:0] send_window;
    logic [1:0]       call_status;
    logic             pending_done;
    logic             ack_mismatch;
    logic [3:0]       conn_state;
  } out_item_t;

endpackage

[sv/tcp_connection_state_machine.sv]
// Open and close state machine of a single TCP connection.
// Input channel (in_valid, in_stall, in_data): each item is an application
// connect, listen or close, an arriving segment, or a timer tick.
// Result channel (out_valid, out_stall, out_data): exactly one item per input
// item, carrying the control segment to send, the call status, completion of
// a blocked connect or accept, the acknowledgment check and the new state.
// Configuration port (cfg_wr_en, cfg_index, cfg_wdata): TIME_WAIT length in
// ticks and the advertised window; write it only while the block is idle.
// An accepted item waits in the input register until the result register is
// free or being emptied, is evaluated against the connection state and lands
// in the result register, from which its result is offered. One item is taken
// every cycle as long as the result register is free or being emptied.
// While the receiver stalls, the result register holds and the input
// register fills, after which in_stall rises and no further item is taken.
// Synchronous reset empties both registers, puts the connection in CLOSED
// with zero sequence numbers and restores the configuration defaults.
module tcp_connection_state_machine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcsm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [tcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                            in_valid_r;
  tcsm_pkg::in_item_t              in_r;
  logic                            out_valid_r;
  tcsm_pkg::out_item_t             out_r;
  tcsm_pkg::out_item_t             res_nxt;
  logic                            adv;
  logic                            fire;

  tcsm_pkg::conn_state_t           st_r;
  tcsm_pkg::conn_state_t           st_nxt;
  logic [tcsm_pkg::SEQ_W-1:0]      snd_r;
  logic [tcsm_pkg::SEQ_W-1:0]      snd_nxt;
  logic [tcsm_pkg::SEQ_W-1:0]      rcv_r;
  logic [tcsm_pkg::SEQ_W-1:0]      rcv_nxt;
  logic [tcsm_pkg::SEQ_W-1:0]      wc_r;
  logic [tcsm_pkg::SEQ_W-1:0]      wc_nxt;
  logic [tcsm_pkg::SEQ_W-1:0]      tw_ticks_r;
  logic [tcsm_pkg::WIN_W-1:0]      win_r;

  logic                            snd_en;
  logic                            snd_syn;
  logic                            snd_ack;
  logic                            snd_fin;
  logic [tcsm_pkg::SEQ_W-1:0]      snd_seq;
  tcsm_pkg::call_status_t          status;
  logic                            done;
  logic                            mism;
  logic [tcsm_pkg::SEQ_W-1:0]      rcv_inc;

  assign adv       = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && adv;
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_ticks_r <= tcsm_pkg::TIME_WAIT_TICKS_RST;
      win_r      <= tcsm_pkg::WINDOW_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tcsm_pkg::CFG_TIME_WAIT_TICKS: tw_ticks_r <= cfg_wdata;
        tcsm_pkg::CFG_WINDOW_SIZE:     win_r <= cfg_wdata[tcsm_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= tcsm_pkg::CONN_CLOSED;
      snd_r <= '0;
      rcv_r <= '0;
      wc_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      snd_r <= snd_nxt;
      rcv_r <= rcv_nxt;
      wc_r  <= wc_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    snd_nxt = snd_r;
    rcv_nxt = rcv_r;
    wc_nxt  = wc_r;
    snd_en  = 1'b0;
    snd_syn = 1'b0;
    snd_ack = 1'b0;
    snd_fin = 1'b0;
    snd_seq = '0;
    status  = tcsm_pkg::ST_NONE;
    done    = 1'b0;
    mism    = 1'b0;
    rcv_inc = in_r.seg_seq + tcsm_pkg::SEQ_W'(1);

    if (fire) begin
      case (in_r.opcode)
        tcsm_pkg::OP_CONNECT: begin
          if (st_r != tcsm_pkg::CONN_CLOSED) begin
            status = tcsm_pkg::ST_ERROR;
          end else begin
            rcv_nxt = '0;
            snd_en  = 1'b1;
            snd_syn = 1'b1;
            snd_seq = in_r.initial_seq;
            snd_nxt = in_r.initial_seq + tcsm_pkg::SEQ_W'(1);
            st_nxt  = tcsm_pkg::CONN_SYN_SENT;
            status  = tcsm_pkg::ST_PENDING;
          end
        end
        tcsm_pkg::OP_LISTEN: begin
          if (st_r == tcsm_pkg::CONN_CLOSED || st_r == tcsm_pkg::CONN_LISTEN) begin
            st_nxt = tcsm_pkg::CONN_LISTEN;
            status = tcsm_pkg::ST_SUCCESS;
          end else begin
            status = tcsm_pkg::ST_ERROR;
          end
        end
        tcsm_pkg::OP_CLOSE: begin
          status = tcsm_pkg::ST_SUCCESS;
          if (st_r == tcsm_pkg::CONN_ESTABLISHED || st_r == tcsm_pkg::CONN_CLOSE_WAIT) begin
            snd_en  = 1'b1;
            snd_ack = 1'b1;
            snd_fin = 1'b1;
            snd_seq = snd_r;
            snd_nxt = snd_r + tcsm_pkg::SEQ_W'(1);
            st_nxt  = (st_r == tcsm_pkg::CONN_ESTABLISHED) ?
                      tcsm_pkg::CONN_FIN_WAIT_1 : tcsm_pkg::CONN_LAST_ACK;
          end else begin
            st_nxt = tcsm_pkg::CONN_CLOSED;
            wc_nxt = '0;
          end
        end
        tcsm_pkg::OP_SEGMENT: begin
          case (st_r)
            tcsm_pkg::CONN_LISTEN: begin
              if (in_r.seg_syn && !in_r.seg_ack) begin
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_syn = 1'b1;
                snd_ack = 1'b1;
                snd_seq = in_r.initial_seq;
                snd_nxt = in_r.initial_seq + tcsm_pkg::SEQ_W'(1);
                st_nxt  = tcsm_pkg::CONN_SYN_RCVD;
              end
            end
            tcsm_pkg::CONN_SYN_SENT: begin
              if (in_r.seg_syn && in_r.seg_ack) begin
                done    = 1'b1;
                mism    = (snd_r != in_r.seg_ack_num);
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_ack = 1'b1;
                snd_seq = snd_r;
                st_nxt  = tcsm_pkg::CONN_ESTABLISHED;
              end else if (in_r.seg_syn) begin
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_syn = 1'b1;
                snd_ack = 1'b1;
                snd_seq = snd_r - tcsm_pkg::SEQ_W'(1);
                st_nxt  = tcsm_pkg::CONN_SYN_SIMRCVD;
              end
            end
            tcsm_pkg::CONN_SYN_RCVD: begin
              if (in_r.seg_ack) begin
                done   = 1'b1;
                mism   = (snd_r != in_r.seg_ack_num);
                st_nxt = tcsm_pkg::CONN_ESTABLISHED;
              end
            end
            tcsm_pkg::CONN_SYN_SIMRCVD: begin
              if (in_r.seg_ack) begin
                done    = 1'b1;
                mism    = (snd_r != in_r.seg_ack_num);
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_ack = 1'b1;
                snd_seq = snd_r;
                st_nxt  = tcsm_pkg::CONN_ESTABLISHED;
              end
            end
            tcsm_pkg::CONN_ESTABLISHED: begin
              if (in_r.seg_fin && in_r.seg_ack) begin
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_ack = 1'b1;
                snd_seq = snd_r;
                st_nxt  = tcsm_pkg::CONN_CLOSE_WAIT;
              end
            end
            tcsm_pkg::CONN_FIN_WAIT_1: begin
              if (in_r.seg_ack) begin
                if (in_r.seg_fin) begin
                  rcv_nxt = rcv_inc;
                  snd_en  = 1'b1;
                  snd_ack = 1'b1;
                  snd_seq = snd_r;
                  st_nxt  = tcsm_pkg::CONN_CLOSING;
                end else begin
                  st_nxt = tcsm_pkg::CONN_FIN_WAIT_2;
                end
              end
            end
            tcsm_pkg::CONN_FIN_WAIT_2: begin
              if (in_r.seg_fin && in_r.seg_ack) begin
                rcv_nxt = rcv_inc;
                snd_en  = 1'b1;
                snd_ack = 1'b1;
                snd_seq = snd_r;
                st_nxt  = tcsm_pkg::CONN_TIME_WAIT;
                wc_nxt  = tw_ticks_r;
              end
            end
            tcsm_pkg::CONN_CLOSING: begin
              if (in_r.seg_ack) begin
                st_nxt = tcsm_pkg::CONN_TIME_WAIT;
                wc_nxt = tw_ticks_r;
              end
            end
            tcsm_pkg::CONN_LAST_ACK: begin
              if (in_r.seg_ack) begin
                st_nxt = tcsm_pkg::CONN_CLOSED;
              end
            end
            default: ;
          endcase
        end
        tcsm_pkg::OP_TICK: begin
          if (st_r == tcsm_pkg::CONN_TIME_WAIT) begin
            if (wc_r <= tcsm_pkg::SEQ_W'(1)) begin
              wc_nxt = '0;
              st_nxt = tcsm_pkg::CONN_CLOSED;
            end else begin
              wc_nxt = wc_r - tcsm_pkg::SEQ_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    res_nxt.send_valid   = snd_en;
    res_nxt.send_syn     = snd_syn;
    res_nxt.send_ack     = snd_ack;
    res_nxt.send_fin     = snd_fin;
    res_nxt.send_seq     = snd_seq;
    res_nxt.send_ack_num = snd_en ? rcv_nxt : '0;
    res_nxt.send_window  = snd_en ? win_r : '0;
    res_nxt.call_status  = status;
    res_nxt.pending_done = done;
    res_nxt.ack_mismatch = mism;
    res_nxt.conn_state   = st_nxt;
  end

endmodule

[sv/tcsm_checker.sv]
module tcsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tcsm_pkg::out_item_t out_data
);

  // A result that is held back keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // After reset no result item is offered.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item offered straight after reset");

  // Without a segment the segment fields are all zero.
  a_no_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.send_valid |->
      !out_data.send_syn && !out_data.send_ack && !out_data.send_fin &&
      out_data.send_seq == '0 && out_data.send_ack_num == '0 &&
      out_data.send_window == '0)
    else $error("segment fields set without a segment");

  // A completed connect or accept always lands in ESTABLISHED.
  a_done_estab: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pending_done |->
      out_data.conn_state == tcsm_pkg::CONN_ESTABLISHED &&
      out_data.call_status == tcsm_pkg::ST_NONE)
    else $error("completion reported outside ESTABLISHED");

  // A blocked connect always sends a SYN and waits in SYN_SENT.
  a_pending_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.call_status == tcsm_pkg::ST_PENDING |->
      out_data.send_valid && out_data.send_syn && !out_data.send_ack &&
      out_data.conn_state == tcsm_pkg::CONN_SYN_SENT)
    else $error("pending connect without a SYN");

endmodule

bind tcp_connection_state_machine tcsm_checker u_tcsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
